/* design/lfa_pkg.sv */
package lfa_pkg;

    // Tag that travels with every request down the pipeline.
    typedef struct packed {
        logic       valid;
        logic [2:0] idx;
    } t_tag;

    localparam logic [2:0] LAST_IDX = 3'd4;

    // One full turn in arcseconds, its scaled reciprocal floor(2^52 / turn),
    // and round(pi / 648000 * 2^81) for the arcsecond to radian step.
    localparam logic [20:0] TURN_ARCSEC = 21'd1296000;
    localparam logic [31:0] TURN_RECIP  = 32'd3474999712;
    localparam logic [63:0] RAD_K       = 64'd11722075535914625249;

    // Polynomial coefficients in arcseconds, signed Q32, indexed [argument][power].
    localparam logic signed [63:0] COEF [5][5] = '{
        '{
            (64'd485868 << 32) + ((64'd249036 << 32) + 64'd500000) / 64'd1000000,
            (64'd1717915923 << 32) + ((64'd2178 << 32) + 64'd5000) / 64'd10000,
            (64'd31 << 32) + ((64'd8792 << 32) + 64'd5000) / 64'd10000,
            ((64'd51635 << 32) + 64'd500000) / 64'd1000000,
            64'd0 - ((64'd24470 << 32) + 64'd50000000) / 64'd100000000
        },
        '{
            (64'd1287104 << 32) + ((64'd793048 << 32) + 64'd500000) / 64'd1000000,
            (64'd129596581 << 32) + ((64'd481 << 32) + 64'd5000) / 64'd10000,
            64'd0 - ((64'd5532 << 32) + 64'd5000) / 64'd10000,
            ((64'd136 << 32) + 64'd500000) / 64'd1000000,
            64'd0 - ((64'd1149 << 32) + 64'd50000000) / 64'd100000000
        },
        '{
            (64'd335779 << 32) + ((64'd526232 << 32) + 64'd500000) / 64'd1000000,
            (64'd1739527262 << 32) + ((64'd8478 << 32) + 64'd5000) / 64'd10000,
            64'd0 - ((64'd12 << 32) + ((64'd7512 << 32) + 64'd5000) / 64'd10000),
            64'd0 - ((64'd1037 << 32) + 64'd500000) / 64'd1000000,
            ((64'd417 << 32) + 64'd50000000) / 64'd100000000
        },
        '{
            (64'd1072260 << 32) + ((64'd703692 << 32) + 64'd500000) / 64'd1000000,
            (64'd1602961601 << 32) + ((64'd2090 << 32) + 64'd5000) / 64'd10000,
            64'd0 - ((64'd6 << 32) + ((64'd3706 << 32) + 64'd5000) / 64'd10000),
            ((64'd6593 << 32) + 64'd500000) / 64'd1000000,
            64'd0 - ((64'd3169 << 32) + 64'd50000000) / 64'd100000000
        },
        '{
            (64'd450160 << 32) + ((64'd398036 << 32) + 64'd500000) / 64'd1000000,
            64'd0 - ((64'd6962890 << 32) + ((64'd5431 << 32) + 64'd5000) / 64'd10000),
            (64'd7 << 32) + ((64'd4722 << 32) + 64'd5000) / 64'd10000,
            ((64'd7702 << 32) + 64'd500000) / 64'd1000000,
            64'd0 - ((64'd5939 << 32) + 64'd50000000) / 64'd100000000
        }
    };

    // Coefficient lookup; codes beyond the last argument read as zero.
    function automatic logic signed [63:0] coef_of(input logic [2:0] idx, input logic [2:0] pw);
        logic signed [63:0] c;
        c = '0;
        if (idx <= LAST_IDX && pw <= 3'd4) begin
            c = COEF[idx][pw];
        end
        return c;
    endfunction

endpackage

/* design/lfa_horner_step.sv */
module lfa_horner_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  lfa_pkg::t_tag       i_tag,
    input  logic signed [47:0]  i_t,
    input  logic signed [63:0]  i_acc,
    input  logic signed [63:0]  i_coef,
    output lfa_pkg::t_tag       o_tag,
    output logic signed [47:0]  o_t,
    output logic signed [73:0]  o_sum
);

    lfa_pkg::t_tag      r_tag_m;
    logic signed [47:0] r_t_m;
    logic signed [63:0] r_coef_m;
    logic signed [57:0] r_ll;
    logic signed [56:0] r_lh;
    logic signed [56:0] r_hl;
    logic signed [55:0] r_hh;

    lfa_pkg::t_tag      r_tag_a;
    logic signed [47:0] r_t_a;
    logic signed [73:0] r_sum;

    logic signed [32:0]  n_al;
    logic signed [31:0]  n_ah;
    logic signed [24:0]  n_tl;
    logic signed [23:0]  n_th;
    logic signed [111:0] n_prod;
    logic signed [111:0] n_shift;
    logic signed [73:0]  n_sum;

    // Split both operands into a signed upper and an unsigned lower half.
    always_comb begin
        n_al = $signed({1'b0, i_acc[31:0]});
        n_ah = $signed(i_acc[63:32]);
        n_tl = $signed({1'b0, i_t[23:0]});
        n_th = $signed(i_t[47:24]);
    end

    // Multiply stage: four partial products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_m.valid <= 1'b0;
        end else if (i_en) begin
            r_tag_m.valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_m.idx <= i_tag.idx;
            r_t_m       <= i_t;
            r_coef_m    <= i_coef;
            r_ll        <= n_al * n_tl;
            r_lh        <= n_al * n_th;
            r_hl        <= n_ah * n_tl;
            r_hh        <= n_ah * n_th;
        end
    end

    // Add stage: combine, floor by 2^40 and add the next coefficient.
    always_comb begin
        n_prod  = (112'(r_hh) <<< 56) + (112'(r_hl) <<< 32) + (112'(r_lh) <<< 24)
                + 112'(r_ll);
        n_shift = n_prod >>> 40;
        n_sum   = 74'(n_shift) + 74'(r_coef_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a.valid <= 1'b0;
        end else if (i_en) begin
            r_tag_a.valid <= r_tag_m.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_a.idx <= r_tag_m.idx;
            r_t_a       <= r_t_m;
            r_sum       <= n_sum;
        end
    end

    assign o_tag = r_tag_a;
    assign o_t   = r_t_a;
    assign o_sum = r_sum;

endmodule

/* design/lfa_reduce.sv */
module lfa_reduce (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  lfa_pkg::t_tag      i_tag,
    input  logic signed [73:0] i_poly,
    output lfa_pkg::t_tag      o_tag,
    output logic               o_neg,
    output logic [52:0]        o_rem
);

    // Entry stage: sign and magnitude.
    lfa_pkg::t_tag r_tag_s;
    logic          r_neg_s;
    logic [73:0]   r_mag_s;

    // Three digit steps, each a multiply stage and a correction stage.
    lfa_pkg::t_tag r_tag_m [3];
    logic          r_neg_m [3];
    logic [73:0]   r_mag_m [3];
    logic [30:0]   r_x     [3];
    logic [62:0]   r_pr    [3];

    lfa_pkg::t_tag r_tag_c [3];
    logic          r_neg_c [3];
    logic [73:0]   r_mag_c [3];
    logic [20:0]   r_rem_c [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_s.valid <= 1'b0;
        end else if (i_en) begin
            r_tag_s.valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_s.idx <= i_tag.idx;
            r_neg_s     <= i_poly[73];
            r_mag_s     <= i_poly[73] ? 74'(-i_poly) : 74'(i_poly);
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_step
        lfa_pkg::t_tag in_tag;
        logic          in_neg;
        logic [73:0]   in_mag;
        logic [20:0]   in_rem;
        logic [9:0]    n_chunk;
        logic [30:0]   n_x;
        logic [10:0]   n_q;
        logic [30:0]   n_d;
        logic [20:0]   n_rem;

        // The leading twelve bits of the turn count are already below one turn.
        if (j == 0) begin : g_first
            assign in_tag = r_tag_s;
            assign in_neg = r_neg_s;
            assign in_mag = r_mag_s;
            assign in_rem = {9'd0, r_mag_s[73:62]};
        end else begin : g_next
            assign in_tag = r_tag_c[j-1];
            assign in_neg = r_neg_c[j-1];
            assign in_mag = r_mag_c[j-1];
            assign in_rem = r_rem_c[j-1];
        end

        // Append the next ten bits and estimate the quotient by reciprocal.
        always_comb begin
            n_chunk = in_mag[61 - 10*j -: 10];
            n_x     = {in_rem[20:0], n_chunk};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag_m[j].valid <= 1'b0;
            end else if (i_en) begin
                r_tag_m[j].valid <= in_tag.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag_m[j].idx <= in_tag.idx;
                r_neg_m[j]     <= in_neg;
                r_mag_m[j]     <= in_mag;
                r_x[j]         <= n_x;
                r_pr[j]        <= 63'(n_x) * 63'(lfa_pkg::TURN_RECIP);
            end
        end

        // The estimate is at most one short, so one subtraction corrects it.
        always_comb begin
            n_q   = r_pr[j][62:52];
            n_d   = r_x[j] - 31'(32'(n_q) * 32'(lfa_pkg::TURN_ARCSEC));
            n_rem = (n_d >= 31'(lfa_pkg::TURN_ARCSEC))
                  ? 21'(n_d - 31'(lfa_pkg::TURN_ARCSEC)) : 21'(n_d);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag_c[j].valid <= 1'b0;
            end else if (i_en) begin
                r_tag_c[j].valid <= r_tag_m[j].valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag_c[j].idx <= r_tag_m[j].idx;
                r_neg_c[j]     <= r_neg_m[j];
                r_mag_c[j]     <= r_mag_m[j];
                r_rem_c[j]     <= n_rem;
            end
        end
    end

    // The fractional arcsecond bits pass through the reduction untouched.
    assign o_tag = r_tag_c[2];
    assign o_neg = r_neg_c[2];
    assign o_rem = {r_rem_c[2], r_mag_c[2][31:0]};

endmodule

/* design/lfa_to_rad.sv */
module lfa_to_rad (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  lfa_pkg::t_tag      i_tag,
    input  logic               i_neg,
    input  logic [52:0]        i_rem,
    output lfa_pkg::t_tag      o_tag,
    output logic signed [63:0] o_angle
);

    lfa_pkg::t_tag r_tag_p;
    logic          r_neg_p;
    logic [63:0]   r_ll;
    logic [63:0]   r_lh;
    logic [52:0]   r_hl;
    logic [52:0]   r_hh;

    lfa_pkg::t_tag r_tag_r;
    logic          r_neg_r;
    logic [63:0]   r_mag;

    lfa_pkg::t_tag      r_tag_o;
    logic signed [63:0] r_angle;

    logic [117:0] n_sum;

    // Product stage: remainder times the radian scale, in four pieces.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_p.valid <= 1'b0;
        end else if (i_en) begin
            r_tag_p.valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_p.idx <= i_tag.idx;
            r_neg_p     <= i_neg;
            r_ll        <= 64'(i_rem[31:0]) * 64'(lfa_pkg::RAD_K[31:0]);
            r_lh        <= 64'(i_rem[31:0]) * 64'(lfa_pkg::RAD_K[63:32]);
            r_hl        <= 53'(i_rem[52:32]) * 53'(lfa_pkg::RAD_K[31:0]);
            r_hh        <= 53'(i_rem[52:32]) * 53'(lfa_pkg::RAD_K[63:32]);
        end
    end

    // Rounding stage: sum, add half an output step and drop 53 bits.
    always_comb begin
        n_sum = 118'(r_ll) + (118'(r_lh) << 32) + (118'(r_hl) << 32) + (118'(r_hh) << 64)
              + (118'd1 << 52);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_r.valid <= 1'b0;
        end else if (i_en) begin
            r_tag_r.valid <= r_tag_p.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_r.idx <= r_tag_p.idx;
            r_neg_r     <= r_neg_p;
            r_mag       <= n_sum[116:53];
        end
    end

    // Output stage: restore the sign of the polynomial value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_o.valid <= 1'b0;
        end else if (i_en) begin
            r_tag_o.valid <= r_tag_r.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_o.idx <= r_tag_r.idx;
            r_angle     <= r_neg_r ? $signed(64'd0 - r_mag) : $signed(r_mag);
        end
    end

    assign o_tag   = r_tag_o;
    assign o_angle = r_angle;

endmodule

/* design/lunisolar_fundamental_arguments_core.sv */
// Lunisolar fundamental arguments.
// Input channel: i_valid, o_stall, i_t_centuries (signed Q8.40 Julian centuries).
// Output channel: o_valid, i_stall, o_arg_index, o_angle_rad (signed Q4.60
// radians) and o_last. Each request yields five results in the order Moon
// anomaly, Sun anomaly, F, D, node longitude; o_last marks the fifth.
// A sequencer holds the time value and, while the pipeline is not held, issues
// one argument per cycle into a single evaluation pipeline; it takes the next
// request as it issues the last argument of the current one, so the output
// carries one result per cycle while requests keep coming and i_stall is low.
// The evaluation pipeline has eight stages of Horner multiply and add, seven
// of turn reduction, and three of radian scaling and rounding.
// Reset clears every valid bit; the block takes a request in the first cycle
// after reset. While i_stall is high with a result on offer, the whole
// pipeline and the sequencer hold, and o_stall rises once the sequencer is
// full.
module lunisolar_fundamental_arguments_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [47:0] i_t_centuries,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_arg_index,
    output logic signed [63:0] o_angle_rad,
    output logic               o_last
);

    logic               r_busy;
    logic [2:0]         r_idx;
    logic signed [47:0] r_t;

    logic          w_en;
    logic          w_accept;
    lfa_pkg::t_tag w_issue;

    lfa_pkg::t_tag      w_tag [5];
    logic signed [47:0] w_t   [5];
    logic signed [73:0] w_sum [4];
    logic signed [63:0] w_acc [4];
    logic signed [63:0] w_cf  [4];

    lfa_pkg::t_tag      w_red_tag;
    logic               w_red_neg;
    logic [52:0]        w_red_rem;
    lfa_pkg::t_tag      w_out_tag;

    // Everything advances unless a result waits on a stalled receiver.
    assign w_en     = !w_out_tag.valid || !i_stall;
    assign o_stall  = r_busy && !(w_en && r_idx == lfa_pkg::LAST_IDX);
    assign w_accept = i_valid && !o_stall;

    // Sequencer: hold the time value and issue the five arguments in turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_en && r_busy) begin
            if (r_idx == lfa_pkg::LAST_IDX) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_t <= i_t_centuries;
        end
    end

    assign w_issue.valid = r_busy;
    assign w_issue.idx   = r_idx;
    assign w_tag[0]      = w_issue;
    assign w_t[0]        = r_t;

    // Horner chain: the leading coefficient enters, then powers three to zero.
    for (genvar k = 0; k < 4; k++) begin : g_horner
        if (k == 0) begin : g_lead
            assign w_acc[k] = lfa_pkg::coef_of(w_tag[k].idx, 3'd4);
        end else begin : g_chain
            assign w_acc[k] = w_sum[k-1][63:0];
        end
        assign w_cf[k] = lfa_pkg::coef_of(w_tag[k].idx, 3'(3 - k));

        lfa_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   (w_tag[k]),
            .i_t     (w_t[k]),
            .i_acc   (w_acc[k]),
            .i_coef  (w_cf[k]),
            .o_tag   (w_tag[k+1]),
            .o_t     (w_t[k+1]),
            .o_sum   (w_sum[k])
        );
    end

    lfa_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag[4]),
        .i_poly  (w_sum[3]),
        .o_tag   (w_red_tag),
        .o_neg   (w_red_neg),
        .o_rem   (w_red_rem)
    );

    lfa_to_rad u_to_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_red_tag),
        .i_neg   (w_red_neg),
        .i_rem   (w_red_rem),
        .o_tag   (w_out_tag),
        .o_angle (o_angle_rad)
    );

    assign o_valid     = w_out_tag.valid;
    assign o_arg_index = w_out_tag.idx;
    assign o_last      = (w_out_tag.idx == lfa_pkg::LAST_IDX);

endmodule
